// ----- hdl/heightmap_height_query_macros.svh -----
// Assertion helpers shared by the queue and back-end RTL files.
`ifndef HEIGHTMAP_HEIGHT_QUERY_MACROS_SVH
`define HEIGHTMAP_HEIGHT_QUERY_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define HHQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhq assertion failed");

// Next-cycle implication, checked out of reset.
`define HHQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhq assertion failed");

`endif

// ----- hdl/hhq_pkg.sv -----
package hhq_pkg;

  localparam int MaxDim  = 256;
  localparam int DimW    = 9;
  localparam int AddrW   = 16;
  localparam int DataW   = 32;
  localparam int FracW   = 16;
  localparam int CfgIdxW = 3;
  localparam int QDepth  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH = 3'd0,
    REG_GRID_DEPTH = 3'd1,
    REG_ORIGIN_X   = 3'd2,
    REG_ORIGIN_Y   = 3'd3,
    REG_ORIGIN_Z   = 3'd4,
    REG_CPU_X      = 3'd5,
    REG_CPU_Z      = 3'd6,
    REG_Z_UP       = 3'd7
  } cfg_reg_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [DimW-1:0]         grid_width;
    logic [DimW-1:0]         grid_depth;
    logic signed [DataW-1:0] origin_x;
    logic signed [DataW-1:0] origin_y;
    logic signed [DataW-1:0] origin_z;
    logic [DataW-1:0]        cpu_x;
    logic [DataW-1:0]        cpu_z;
    logic                    z_up;
  } cfg_t;

  // One classified request travelling from front to back.
  typedef struct packed {
    logic                    is_query;
    logic [AddrW-1:0]        widx;
    logic signed [DataW-1:0] wval;
    logic signed [DataW-1:0] px;
    logic signed [DataW-1:0] py;
    logic signed [DataW-1:0] pz;
    logic                    in_cell;
    logic                    sel_up;
    logic [FracW-1:0]        fx;
    logic [FracW-1:0]        fz;
    logic [AddrW-1:0]        a00;
    logic [AddrW-1:0]        a11;
    logic [AddrW-1:0]        acr;
  } q_item_t;

endpackage

// ----- hdl/hhq_if.sv -----
interface hhq_in_if;
  import hhq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [AddrW-1:0]        sample_index;
  logic signed [DataW-1:0] sample_value;
  logic signed [DataW-1:0] pos_x;
  logic signed [DataW-1:0] pos_y;
  logic signed [DataW-1:0] pos_z;
  modport source (output valid, command, sample_index, sample_value, pos_x, pos_y, pos_z,
                  input ready);
  modport sink (input valid, command, sample_index, sample_value, pos_x, pos_y, pos_z,
                output ready);
endinterface

interface hhq_out_if;
  import hhq_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] out_x;
  logic signed [DataW-1:0] out_y;
  logic signed [DataW-1:0] out_z;
  logic                    inside_res;
  modport source (output valid, out_x, out_y, out_z, inside_res, input ready);
  modport sink (input valid, out_x, out_y, out_z, inside_res, output ready);
endinterface

interface hhq_cfg_if;
  import hhq_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [DataW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/hhq_queue.sv -----
module hhq_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  hhq_pkg::q_item_t din,
  output logic             full,
  input  logic             pop,
  output hhq_pkg::q_item_t dout,
  output logic             empty
);
  import hhq_pkg::*;
  `include "heightmap_height_query_macros.svh"

  localparam int PtrW = $clog2(QDepth);
  localparam int CntW = $clog2(QDepth + 1);

  q_item_t         buf_r [QDepth];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [CntW-1:0] cnt_r;

  assign full  = (cnt_r == CntW'(QDepth));
  assign empty = (cnt_r == '0);
  assign dout  = buf_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PtrW'(1);
      if (pop)  rp_r <= rp_r + PtrW'(1);
      cnt_r <= cnt_r + CntW'(push) - CntW'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) buf_r[wp_r] <= din;
  end

  `HHQ_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CntW'(QDepth))
  `HHQ_ASSERT_NOW(a_no_push_full, push, !full)
  `HHQ_ASSERT_NOW(a_no_pop_empty, pop, !empty)
  `HHQ_ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_r == $past(cnt_r) + CntW'(1))

endmodule

// ----- hdl/hhq_front.sv -----
module hhq_front (
  input  logic             clk,
  input  logic             rst_n,
  hhq_in_if.sink           in_,
  input  hhq_pkg::cfg_t    cfg,
  output logic             push,
  output hhq_pkg::q_item_t item,
  input  logic             full
);
  import hhq_pkg::*;

  typedef struct packed {
    logic                    is_query;
    logic [AddrW-1:0]        widx;
    logic signed [DataW-1:0] wval;
    logic signed [DataW-1:0] px;
    logic signed [DataW-1:0] py;
    logic signed [DataW-1:0] pz;
  } pass_t;

  localparam int OffW  = DataW + 2;
  localparam int MagW  = DataW + 1;
  localparam int ProdW = MagW + DataW;

  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  pass_t p1_r, p2_r, p3_r;
  logic signed [OffW-1:0] ox1_r, oz1_r;
  logic [MagW-1:0] mx2_r, mz2_r;
  logic nx2_r, nz2_r, nx3_r, nz3_r;
  logic [ProdW-1:0] prx3_r, prz3_r;
  q_item_t item4_r;

  logic signed [OffW-1:0] yz, ox_nxt, oz_nxt;
  logic [MagW-1:0] mx_nxt, mz_nxt;
  logic [ProdW-1:0] prx_nxt, prz_nxt;
  logic [DimW-1:0] w_eff, d_eff;
  logic [MagW-1:0] cx, cz;
  logic okx, okz;
  logic [2*DimW-1:0] base;
  logic [AddrW-1:0] a00;
  q_item_t item_nxt;

  assign adv       = !v4_r || !full;
  assign in_.ready = adv;
  assign push      = v4_r && !full;
  assign item      = item4_r;

  // stage 1: frame change and origin offsets
  always_comb begin
    yz = cfg.z_up ? -OffW'(in_.pos_y) : OffW'(in_.pos_z);
    ox_nxt = OffW'(in_.pos_x) - OffW'(cfg.origin_x);
    oz_nxt = yz - OffW'(cfg.origin_z);
  end

  // stage 2: sign and magnitude
  always_comb begin
    mx_nxt = MagW'(ox1_r[OffW-1] ? -ox1_r : ox1_r);
    mz_nxt = MagW'(oz1_r[OffW-1] ? -oz1_r : oz1_r);
  end

  // stage 3: scale into grid units, 33 x 32 split as 32 x 32 plus a shifted add
  always_comb begin
    prx_nxt = ProdW'(mx2_r[DataW-1:0] * cfg.cpu_x)
            + (mx2_r[MagW-1] ? {1'b0, cfg.cpu_x, {DataW{1'b0}}} : '0);
    prz_nxt = ProdW'(mz2_r[DataW-1:0] * cfg.cpu_z)
            + (mz2_r[MagW-1] ? {1'b0, cfg.cpu_z, {DataW{1'b0}}} : '0);
  end

  // stage 4: cell select, bounds and store addresses
  always_comb begin
    w_eff = (int'(cfg.grid_width) > MaxDim) ? DimW'(MaxDim) : cfg.grid_width;
    d_eff = (int'(cfg.grid_depth) > MaxDim) ? DimW'(MaxDim) : cfg.grid_depth;
    cx = prx3_r[ProdW-1:DataW];
    cz = prz3_r[ProdW-1:DataW];
    okx = !(nx3_r && prx3_r != '0) && (w_eff >= DimW'(2))
          && (cx < MagW'(w_eff) - MagW'(1));
    okz = !(nz3_r && prz3_r != '0) && (d_eff >= DimW'(2))
          && (cz < MagW'(d_eff) - MagW'(1));
    base = cz[DimW-1:0] * w_eff + (2*DimW)'(cx[DimW-1:0]);
    a00 = base[AddrW-1:0];
    item_nxt.is_query = p3_r.is_query;
    item_nxt.widx     = p3_r.widx;
    item_nxt.wval     = p3_r.wval;
    item_nxt.px       = p3_r.px;
    item_nxt.py       = p3_r.py;
    item_nxt.pz       = p3_r.pz;
    item_nxt.in_cell  = okx && okz;
    item_nxt.fx       = prx3_r[DataW-1:FracW];
    item_nxt.fz       = prz3_r[DataW-1:FracW];
    item_nxt.sel_up   = item_nxt.fx < item_nxt.fz;
    item_nxt.a00      = a00;
    item_nxt.a11      = a00 + AddrW'(w_eff) + AddrW'(1);
    item_nxt.acr      = item_nxt.sel_up ? a00 + AddrW'(w_eff) : a00 + AddrW'(1);
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    if (adv) begin
      p1_r.is_query <= (in_.command == CMD_QUERY);
      p1_r.widx     <= in_.sample_index;
      p1_r.wval     <= in_.sample_value;
      p1_r.px       <= in_.pos_x;
      p1_r.py       <= in_.pos_y;
      p1_r.pz       <= in_.pos_z;
      ox1_r         <= ox_nxt;
      oz1_r         <= oz_nxt;
      p2_r          <= p1_r;
      mx2_r         <= mx_nxt;
      mz2_r         <= mz_nxt;
      nx2_r         <= ox1_r[OffW-1];
      nz2_r         <= oz1_r[OffW-1];
      p3_r          <= p2_r;
      prx3_r        <= prx_nxt;
      prz3_r        <= prz_nxt;
      nx3_r         <= nx2_r;
      nz3_r         <= nz2_r;
      item4_r       <= item_nxt;
    end
  end

endmodule

// ----- hdl/hhq_back.sv -----
module hhq_back (
  input  logic             clk,
  input  logic             rst_n,
  input  hhq_pkg::cfg_t    cfg,
  input  hhq_pkg::q_item_t item,
  input  logic             empty,
  output logic             pop,
  hhq_out_if.source        out_
);
  import hhq_pkg::*;
  `include "heightmap_height_query_macros.svh"

  localparam int StoreD = 1 << AddrW;
  localparam int DiffW  = DataW + 1;
  localparam int MulW   = DiffW + FracW + 1;
  localparam int AccW   = MulW + 1;
  localparam int FlW    = AccW - FracW;
  localparam int HW     = FlW + 2;

  // two copies: one with two read ports, one with one
  logic signed [DataW-1:0] mem_a [StoreD];
  logic signed [DataW-1:0] mem_b [StoreD];

  logic adv;
  logic b0_v_r, b1_v_r, b2_v_r, out_v_r;
  q_item_t b0_r, b1_r, b2_r;
  logic signed [DataW-1:0] h00_r, h11_r, hc_r, h00b1_r, h00b2_r;
  logic signed [DiffW-1:0] a_r, b_r;
  logic signed [MulW-1:0] pa_r, pb_r;
  logic signed [DataW-1:0] ox_r, oy_r, oz_r;
  logic ins_r;

  logic signed [DiffW-1:0] d_lo, d_hi, a_nxt, b_nxt;
  logic signed [AccW-1:0] acc;
  logic signed [HW-1:0] h;
  logic signed [DataW-1:0] hs;

  assign adv = !out_v_r || out_.ready;
  assign pop = adv && !empty;

  assign out_.valid      = out_v_r;
  assign out_.out_x      = ox_r;
  assign out_.out_y      = oy_r;
  assign out_.out_z      = oz_r;
  assign out_.inside_res = ins_r;

  // store write and read, same stage for every request
  always_ff @(posedge clk) begin
    if (pop && !item.is_query) begin
      mem_a[item.widx] <= item.wval;
      mem_b[item.widx] <= item.wval;
    end
    if (pop) begin
      h00_r <= mem_a[item.a00];
      h11_r <= mem_a[item.a11];
      hc_r  <= mem_b[item.acr];
    end
  end

  // plane slopes for the chosen triangle
  always_comb begin
    d_lo  = DiffW'(hc_r) - DiffW'(h00_r);
    d_hi  = DiffW'(h11_r) - DiffW'(hc_r);
    a_nxt = b0_r.sel_up ? d_hi : d_lo;
    b_nxt = b0_r.sel_up ? d_lo : d_hi;
  end

  // sum, floor to Q16.16, base heights, saturate
  always_comb begin
    acc = AccW'(pa_r) + AccW'(pb_r);
    h = HW'($signed(acc[AccW-1:FracW])) + HW'(h00b2_r) + HW'(cfg.origin_y);
    if (h > HW'(64'sh7fff_ffff))
      hs = {1'b0, {(DataW-1){1'b1}}};
    else if (h < -HW'(64'sh8000_0000))
      hs = {1'b1, {(DataW-1){1'b0}}};
    else
      hs = h[DataW-1:0];
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_v_r  <= 1'b0;
      b1_v_r  <= 1'b0;
      b2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      b0_v_r  <= pop;
      b1_v_r  <= b0_v_r;
      b2_v_r  <= b1_v_r;
      out_v_r <= b2_v_r && b2_r.is_query;
    end
  end

  // payload chain
  always_ff @(posedge clk) begin
    if (adv) begin
      b0_r    <= item;
      b1_r    <= b0_r;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      h00b1_r <= h00_r;
      b2_r    <= b1_r;
      pa_r    <= a_r * $signed({1'b0, b1_r.fx});
      pb_r    <= b_r * $signed({1'b0, b1_r.fz});
      h00b2_r <= h00b1_r;
      ox_r    <= b2_r.px;
      oy_r    <= (b2_r.in_cell && !cfg.z_up) ? hs : b2_r.py;
      oz_r    <= (b2_r.in_cell && cfg.z_up) ? hs : b2_r.pz;
      ins_r   <= b2_r.in_cell;
    end
  end

  `HHQ_ASSERT_NEXT(a_write_silent, adv && b2_v_r && !b2_r.is_query, !out_v_r)
  `HHQ_ASSERT_NEXT(a_hold_stall, out_v_r && !out_.ready, out_v_r && $stable(ox_r))
  `HHQ_ASSERT_NOW(a_pop_adv, pop, adv && !empty)

endmodule

// ----- hdl/heightmap_height_query.sv -----
// Path: front stages, queue, then store read, slope, product and output registers.
// Rate: one request per cycle unless stalled; queries, writes mix freely; writes give no result.
// Store: two 64K x 32 copies, written together, read at three addresses in one cycle.
// A 4-entry queue separates address generation from store access and interpolation.
// Reset: synchronous active-low; clears valids and queue, sets config to defaults; store contents undefined.
module heightmap_height_query (
  input logic        clk,
  input logic        rst_n,
  hhq_in_if.sink     in_,
  hhq_out_if.source  out_,
  hhq_cfg_if.sink    cfg_
);
  import hhq_pkg::*;

  cfg_t cfg_r;
  logic push, pop, full, empty;
  q_item_t q_in, q_out;

  assign cfg_.ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_width <= DimW'(256);
      cfg_r.grid_depth <= DimW'(256);
      cfg_r.origin_x   <= '0;
      cfg_r.origin_y   <= '0;
      cfg_r.origin_z   <= '0;
      cfg_r.cpu_x      <= DataW'(32'h0001_0000);
      cfg_r.cpu_z      <= DataW'(32'h0001_0000);
      cfg_r.z_up       <= 1'b0;
    end else if (cfg_.valid) begin
      case (cfg_reg_t'(cfg_.index))
        REG_GRID_WIDTH: cfg_r.grid_width <= cfg_.data[DimW-1:0];
        REG_GRID_DEPTH: cfg_r.grid_depth <= cfg_.data[DimW-1:0];
        REG_ORIGIN_X:   cfg_r.origin_x   <= cfg_.data;
        REG_ORIGIN_Y:   cfg_r.origin_y   <= cfg_.data;
        REG_ORIGIN_Z:   cfg_r.origin_z   <= cfg_.data;
        REG_CPU_X:      cfg_r.cpu_x      <= cfg_.data;
        REG_CPU_Z:      cfg_r.cpu_z      <= cfg_.data;
        REG_Z_UP:       cfg_r.z_up       <= cfg_.data[0];
        default: ;
      endcase
    end
  end

  hhq_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_   (in_),
    .cfg   (cfg_r),
    .push  (push),
    .item  (q_in),
    .full  (full)
  );

  hhq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_in),
    .full  (full),
    .pop   (pop),
    .dout  (q_out),
    .empty (empty)
  );

  hhq_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .item  (q_out),
    .empty (empty),
    .pop   (pop),
    .out_  (out_)
  );

endmodule

// ----- verif/heightmap_height_query_tb.sv -----
module heightmap_height_query_tb;
  import hhq_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    logic                    in_cell;
  } height_res_t;

  typedef struct {
    cmd_t              cmd;
    logic [AddrW-1:0]  idx;
    logic [DataW-1:0]  val;
    logic [DataW-1:0]  px;
    logic [DataW-1:0]  py;
    logic [DataW-1:0]  pz;
    bit                typed;
    height_res_t       res;
  } dir_row_t;

  typedef struct {
    logic [DimW-1:0]  w;
    logic [DimW-1:0]  d;
    logic [DataW-1:0] ox;
    logic [DataW-1:0] oy;
    logic [DataW-1:0] oz;
    logic [DataW-1:0] cx;
    logic [DataW-1:0] cz;
    bit               zup;
    int               fill_w;
    int               fill_d;
    int               n_items;
  } terrain_setup_t;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hhq_in_if  in_if ();
  hhq_out_if out_if ();
  hhq_cfg_if cfg_if ();

  heightmap_height_query i_dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_  (in_if),
    .out_ (out_if),
    .cfg_ (cfg_if)
  );

  // Shadow of the block: registers and height samples
  cfg_t                    terrain_cfg;
  logic signed [DataW-1:0] heights [0:65535];
  bit                      written [0:65535];

  height_res_t pending_heights[$];
  int          err_cnt = 0;
  int          mism_cnt = 0;
  int          results_seen = 0;
  int          hold_cnt = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Expected result of a query; reads_ok is low if an unwritten sample would be read
  function automatic height_res_t predict_height(input logic signed [DataW-1:0] px,
                                                 input logic signed [DataW-1:0] py,
                                                 input logic signed [DataW-1:0] pz,
                                                 output bit reads_ok);
    longint      offx, offz, h00, h11, hc, a, b, acc, h;
    logic [63:0] magx, magz, cellx, cellz, w, d, base;
    logic [15:0] fx, fz, a00, a11, a01, a10;
    bit          in_cell;
    height_res_t r;
    w = (terrain_cfg.grid_width > MaxDim) ? MaxDim : terrain_cfg.grid_width;
    d = (terrain_cfg.grid_depth > MaxDim) ? MaxDim : terrain_cfg.grid_depth;
    offx = longint'(px) - longint'(terrain_cfg.origin_x);
    offz = (terrain_cfg.z_up ? -longint'(py) : longint'(pz)) - longint'(terrain_cfg.origin_z);
    magx = 64'(offx < 0 ? -offx : offx) * 64'(terrain_cfg.cpu_x);
    magz = 64'(offz < 0 ? -offz : offz) * 64'(terrain_cfg.cpu_z);
    cellx = magx >> 32;
    cellz = magz >> 32;
    fx = magx[31:16];
    fz = magz[31:16];
    in_cell = !(offx < 0 && magx != 0) && !(offz < 0 && magz != 0)
              && (cellx + 1 < w) && (cellz + 1 < d);
    r = '{px, py, pz, in_cell};
    reads_ok = 1'b1;
    if (in_cell) begin
      base = cellz * w + cellx;
      a00 = base[15:0];
      a01 = 16'(base + w);
      a10 = 16'(base + 1);
      a11 = 16'(base + w + 1);
      reads_ok = written[a00] && written[a01] && written[a10] && written[a11];
      h00 = heights[a00];
      h11 = heights[a11];
      // lower or upper triangle of the cell
      if (fx < fz) begin
        hc = heights[a01];
        b = hc - h00;
        a = h11 - hc;
      end else begin
        hc = heights[a10];
        a = hc - h00;
        b = h11 - hc;
      end
      acc = a * longint'(fx) + b * longint'(fz);
      acc = acc >>> 16;
      h = acc + h00 + longint'(terrain_cfg.origin_y);
      if (h > 64'sd2147483647) h = 64'sd2147483647;
      if (h < -64'sd2147483648) h = -64'sd2147483648;
      if (terrain_cfg.z_up) r.z = h[31:0];
      else r.y = h[31:0];
    end
    return r;
  endfunction

  // Register write through the config channel, only while idle
  task automatic write_reg(input cfg_reg_t idx, input logic [DataW-1:0] data);
    cfg_if.index = idx;
    cfg_if.data = data;
    cfg_if.valid = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_GRID_WIDTH: terrain_cfg.grid_width = data[DimW-1:0];
      REG_GRID_DEPTH: terrain_cfg.grid_depth = data[DimW-1:0];
      REG_ORIGIN_X:   terrain_cfg.origin_x = data;
      REG_ORIGIN_Y:   terrain_cfg.origin_y = data;
      REG_ORIGIN_Z:   terrain_cfg.origin_z = data;
      REG_CPU_X:      terrain_cfg.cpu_x = data;
      REG_CPU_Z:      terrain_cfg.cpu_z = data;
      REG_Z_UP:       terrain_cfg.z_up = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // One request on the input channel; expectation recorded at acceptance
  task automatic send_request(input cmd_t cmd, input logic [AddrW-1:0] idx,
                              input logic [DataW-1:0] val, input logic [DataW-1:0] px,
                              input logic [DataW-1:0] py, input logic [DataW-1:0] pz,
                              input bit typed, input height_res_t typed_res);
    bit          ok;
    height_res_t exp_res;
    while (!quiet && $urandom_range(0, 99) < 38) @(negedge clk);
    in_if.command = cmd;
    in_if.sample_index = idx;
    in_if.sample_value = val;
    in_if.pos_x = px;
    in_if.pos_y = py;
    in_if.pos_z = pz;
    in_if.valid = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    if (cmd == CMD_WRITE) begin
      heights[idx] = val;
      written[idx] = 1'b1;
    end else begin
      exp_res = typed ? typed_res : predict_height(px, py, pz, ok);
      pending_heights.insert(pending_heights.size(), exp_res);
    end
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic wait_drained(input int extra);
    while (pending_heights.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Random offset in world units covering the written patch and a margin around it
  function automatic longint patch_offset(input int dim, input logic [DataW-1:0] cpu);
    longint span;
    span = (dim < 1 || cpu == 0) ? 64'sh10000 : (longint'(dim) <<< 32) / longint'(cpu);
    if (span > 64'sh40000000) span = 64'sh40000000;
    if (span < 1) span = 1;
    return longint'($urandom_range(0, 32'(span + span / 4))) - span / 8;
  endfunction

  task automatic run_setup(input terrain_setup_t s);
    int               w_eff;
    int               tries;
    longint           offx, offz;
    logic [DataW-1:0] px, py, pz, zc;
    bit               ok;
    height_res_t      r;
    w_eff = (s.w > MaxDim) ? MaxDim : s.w;
    write_reg(REG_GRID_WIDTH, 32'(s.w));
    write_reg(REG_GRID_DEPTH, 32'(s.d));
    write_reg(REG_ORIGIN_X, s.ox);
    write_reg(REG_ORIGIN_Y, s.oy);
    write_reg(REG_ORIGIN_Z, s.oz);
    write_reg(REG_CPU_X, s.cx);
    write_reg(REG_CPU_Z, s.cz);
    write_reg(REG_Z_UP, 32'(s.zup));
    // load the patch of samples the queries will land on
    for (int zi = 0; zi < s.fill_d; zi++)
      for (int xi = 0; xi < s.fill_w; xi++)
        send_request(CMD_WRITE, 16'(zi * w_eff + xi), $urandom, $urandom, $urandom, $urandom,
                     1'b0, '0);
    for (int n = 0; n < s.n_items; n++) begin
      quiet = (s.fill_w == 16 && n < 150);
      if (s.fill_w == 6 && n == 100) wait_drained(0);
      if ($urandom_range(0, 99) < 15) begin
        send_request(CMD_WRITE, 16'($urandom), $urandom, $urandom, $urandom, $urandom,
                     1'b0, '0);
        continue;
      end
      ok = 1'b0;
      for (tries = 0; tries < 50 && !ok; tries++) begin
        if ($urandom_range(0, 99) < 12) begin
          px = $urandom;
          py = $urandom;
          pz = $urandom;
        end else begin
          offx = patch_offset(s.fill_w, s.cx);
          offz = patch_offset(s.fill_d, s.cz);
          px = 32'(longint'($signed(s.ox)) + offx);
          zc = 32'(longint'($signed(s.oz)) + offz);
          if (s.zup) begin
            py = -zc;
            pz = $urandom;
          end else begin
            py = $urandom;
            pz = zc;
          end
        end
        r = predict_height(px, py, pz, ok);
      end
      if (ok) send_request(CMD_QUERY, 16'($urandom), $urandom, px, py, pz, 1'b0, '0);
      else send_request(CMD_WRITE, 16'($urandom), $urandom, px, py, pz, 1'b0, '0);
    end
    quiet = 1'b0;
    wait_drained(DrainCycles);
  endtask

  // Directed table at reset settings: 256 x 256 grid, unit scale, origin zero
  dir_row_t dir_rows[14] = '{
    '{CMD_WRITE, 16'd0,      32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_WRITE, 16'd1,      32'h0002_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_WRITE, 16'd256,    32'h0003_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_WRITE, 16'd257,    32'h0004_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_WRITE, 16'hffff,   32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_WRITE, 16'd2,      32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 1'b0, '0},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h0, 32'h0000_dead, 32'h0, 1'b1,
      '{32'h0, 32'h0001_0000, 32'h0, 1'b1}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h8000, 32'h5, 32'h0, 1'b1,
      '{32'h8000, 32'h0001_8000, 32'h0, 1'b1}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h0, 32'h7, 32'h8000, 1'b1,
      '{32'h0, 32'h0002_0000, 32'h8000, 1'b1}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h4000, 32'h0, 32'h4000, 1'b1,
      '{32'h4000, 32'h0001_c000, 32'h4000, 1'b1}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h0, 1'b1,
      '{32'hffff_ffff, 32'h7fff_ffff, 32'h0, 1'b0}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1,
      '{32'h0, 32'h0, 32'h8000_0000, 1'b0}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b1,
      '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0}},
    '{CMD_QUERY, 16'h0, 32'h0, 32'h0000_ffff, 32'h0, 32'h0000_ffff, 1'b0, '0}
  };

  terrain_setup_t setups[6] = '{
    '{9'd4,   9'd3,   32'h0003_2000, 32'hfff0_0000, 32'hffff_8000, 32'h0001_0000,
      32'h0001_0000, 1'b0, 4, 3, 190},
    '{9'd2,   9'd2,   32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0000_8000,
      32'h0002_0000, 1'b1, 2, 2, 190},
    '{9'd511, 9'd300, 32'h0,         32'h8000_0000, 32'h0,         32'hffff_ffff,
      32'h0000_0100, 1'b0, 6, 6, 190},
    '{9'd1,   9'd5,   32'h0,         32'h0,         32'h0,         32'h0001_0000,
      32'h0,         1'b1, 0, 0, 160},
    '{9'd16,  9'd9,   32'hfffe_0000, 32'h0012_3456, 32'h0004_0000, 32'h0001_8000,
      32'h0000_c000, 1'b0, 16, 9, 190},
    '{9'd256, 9'd2,   32'h0100_0000, 32'hff00_0000, 32'h0, 32'h0001_0000,
      32'h0,         1'b1, 8, 2, 190}
  };

  // Stimulus
  initial begin
    in_if.valid = 1'b0;
    in_if.command = CMD_WRITE;
    in_if.sample_index = '0;
    in_if.sample_value = '0;
    in_if.pos_x = '0;
    in_if.pos_y = '0;
    in_if.pos_z = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_GRID_WIDTH;
    cfg_if.data = '0;
    terrain_cfg = '{9'd256, 9'd256, 32'sh0, 32'sh0, 32'sh0, 32'h0001_0000, 32'h0001_0000, 1'b0};
    foreach (written[i]) written[i] = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (dir_rows[i])
      send_request(dir_rows[i].cmd, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].px,
                   dir_rows[i].py, dir_rows[i].pz, dir_rows[i].typed, dir_rows[i].res);
    wait_drained(DrainCycles);
    foreach (setups[i]) run_setup(setups[i]);
    wait_drained(DrainCycles);
    if (err_cnt == 0) begin
      $display("heightmap_height_query_tb: PASS");
    end else begin
      $display("heightmap_height_query_tb: FAIL");
    end
    $finish;
  end

  // Result side ready: random stalls plus one long hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cnt > 0) begin
        out_if.ready = 1'b0;
        hold_cnt--;
      end else begin
        out_if.ready = rst_n && (quiet || $urandom_range(0, 99) >= 38);
      end
    end
  end

  // Result checking against the oldest expectation
  always @(posedge clk) begin
    height_res_t got, want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = '{out_if.out_x, out_if.out_y, out_if.out_z, out_if.inside_res};
      results_seen++;
      if (results_seen == 60) hold_cnt = 300;
      if (pending_heights.size() == 0) begin
        err_cnt++;
        if (mism_cnt++ < 10) $display("unexpected result x=%h y=%h z=%h inside=%b",
                                      got.x, got.y, got.z, got.in_cell);
      end else begin
        want = pending_heights.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (mism_cnt++ < 10)
            $display("mismatch: exp x=%h y=%h z=%h inside=%b, got x=%h y=%h z=%h inside=%b",
                     want.x, want.y, want.z, want.in_cell, got.x, got.y, got.z, got.in_cell);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("heightmap_height_query_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
